// ----- src/grs_pkg.sv -----
// shared types and constants for the group reverse stream block
package grs_pkg;

    localparam int DATA_W = 32;
    localparam int GS_W = 5;
    localparam logic [GS_W-1:0] GS_RESET = 5'd2;

    typedef enum logic [2:0] {
        ST_FILL = 3'b001,
        ST_LOAD = 3'b010,
        ST_SHOW = 3'b100
    } state_t;

    typedef struct packed {
        logic store;
        logic load_first;
        logic load_next;
    } cmd_t;

    typedef struct packed {
        logic group_done;
        logic show_last;
    } status_t;

endpackage

// ----- src/group_reverse_stream.sv -----
// group reverse stream top level: controller plus datapath
// Values are collected into a group memory of MAX_GROUP entries; when the
// count reaches the configured group size (0 acts as 1, values above
// MAX_GROUP act as MAX_GROUP) the group is sent newest first, and an item
// with s_tlast that leaves a partial group sends that group oldest first.
// m_tlast marks the last transfer of each run and m_tuser the last transfer
// of the sequence. Each input transfer takes one cycle while a group fills;
// the run of results then follows, since the single-port group memory has a
// registered read and the controller holds s_tready low until the run has
// drained, so no new value is taken while a run is shown. Write cfg_wdata
// only while idle.
module group_reverse_stream #(
    parameter int MAX_GROUP = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [grs_pkg::GS_W-1:0]   cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [grs_pkg::DATA_W-1:0] s_tdata,   // value
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [grs_pkg::DATA_W-1:0] m_tdata,   // out_value
    output logic                       m_tlast,
    output logic                       m_tuser    // seq_end
);

    grs_pkg::cmd_t    cmd;
    grs_pkg::status_t status;

    grs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grs_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- src/grs_ctrl.sv -----
// controller state machine: fill, first read, show results
module grs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  grs_pkg::status_t status,
    output grs_pkg::cmd_t   cmd
);

    grs_pkg::state_t state_reg;
    grs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grs_pkg::ST_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            grs_pkg::ST_FILL: begin
                if (s_tvalid) begin
                    cmd.store = 1'b1;
                    if (status.group_done) begin
                        state_next = grs_pkg::ST_LOAD;
                    end
                end
            end
            grs_pkg::ST_LOAD: begin
                cmd.load_first = 1'b1;
                state_next = grs_pkg::ST_SHOW;
            end
            grs_pkg::ST_SHOW: begin
                if (m_tready) begin
                    if (status.show_last) begin
                        state_next = grs_pkg::ST_FILL;
                    end else begin
                        cmd.load_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = grs_pkg::ST_FILL;
            end
        endcase
    end

    assign s_tready = (state_reg == grs_pkg::ST_FILL);
    assign m_tvalid = (state_reg == grs_pkg::ST_SHOW);

endmodule

// ----- src/grs_datapath.sv -----
// datapath: group memory, fill count, drain position and result register
module grs_datapath #(
    parameter int MAX_GROUP = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [grs_pkg::GS_W-1:0]   cfg_wdata,
    input  logic [grs_pkg::DATA_W-1:0] s_tdata,
    input  logic                       s_tlast,
    input  grs_pkg::cmd_t              cmd,
    output grs_pkg::status_t           status,
    output logic [grs_pkg::DATA_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic [grs_pkg::DATA_W-1:0] mem [MAX_GROUP];

    logic [grs_pkg::GS_W-1:0]   group_size_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           len_reg;
    logic [CNT_W-1:0]           pos_reg;
    logic                       rev_reg;
    logic                       seq_reg;
    logic [grs_pkg::DATA_W-1:0] data_reg;
    logic                       run_end_reg;
    logic                       seq_end_reg;

    logic [CNT_W-1:0] eff_size;
    logic [CNT_W-1:0] count_plus;
    logic             full;
    logic [CNT_W-1:0] rd_pos;
    logic [CNT_W-1:0] rd_addr;
    logic             rd_last;

    // effective group size: zero reads as one, saturates at the buffer depth
    always_comb begin
        if (group_size_reg == '0) begin
            eff_size = CNT_W'(1);
        end else if (int'(group_size_reg) > MAX_GROUP) begin
            eff_size = CNT_W'(MAX_GROUP);
        end else begin
            eff_size = CNT_W'(group_size_reg);
        end
    end

    assign count_plus = count_reg + CNT_W'(1);
    assign full = (count_plus >= eff_size);
    assign status.group_done = full || s_tlast;
    assign status.show_last = run_end_reg;

    always_comb begin
        count_next = count_reg;
        if (cmd.store) begin
            count_next = status.group_done ? '0 : count_plus;
        end
    end

    // read position: first entry on a new run, else one past the shown one
    assign rd_pos = cmd.load_first ? '0 : pos_reg;
    assign rd_addr = rev_reg ? (len_reg - CNT_W'(1) - rd_pos) : rd_pos;
    assign rd_last = (rd_pos == len_reg - CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= grs_pkg::GS_RESET;
            count_reg <= '0;
        end else begin
            if (cfg_we) begin
                group_size_reg <= cfg_wdata;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[count_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (cmd.store && status.group_done) begin
            len_reg <= count_plus;
            rev_reg <= full;
            seq_reg <= s_tlast;
        end
        if (cmd.load_first || cmd.load_next) begin
            data_reg <= mem[rd_addr[IDX_W-1:0]];
            run_end_reg <= rd_last;
            seq_end_reg <= rd_last && seq_reg;
            pos_reg <= rd_pos + CNT_W'(1);
        end
    end

    assign m_tdata = data_reg;
    assign m_tlast = run_end_reg;
    assign m_tuser = seq_end_reg;

endmodule

// ----- src/grs_checker.sv -----
// port-level checker for the group reverse stream block, with its bind
module grs_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tlast,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [grs_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tlast,
    input logic                       m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    // input and output sides never both open
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result shown");

    // sequence end only on a run end
    a_seq_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("sequence end without run end");

    // input ending the sequence always starts a drain
    a_last_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready && !m_tvalid)
        else $error("sequence end did not start a drain");

    // a finished run reopens the input side
    a_run_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("input not reopened after run");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- test/tb.sv -----
// testbench for group_reverse_stream: stream driver, receiver and group reorder scoreboard
`timescale 1ns / 100ps

module tb;

    localparam int MAX_GROUP = 16;
    localparam int DIRECTED_ITEMS = 26;
    localparam int RANDOM_ITEMS = 344;
    localparam int QUIET_TAIL = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD = 150;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [grs_pkg::DATA_W-1:0] value;
        logic                       run_end;
        logic                       seq_end;
    } result_t;

    class group_reorder;
        logic [grs_pkg::DATA_W-1:0] group_mem [MAX_GROUP];
        int unsigned                fill_level;
        logic [grs_pkg::GS_W-1:0]   group_size;
        result_t                    expected_out [$];
        int unsigned                results_seen;
        int unsigned                mismatches;

        function new();
            group_size = grs_pkg::GS_RESET;
            fill_level = 0;
            results_seen = 0;
            mismatches = 0;
        endfunction

        function void set_group_size(logic [grs_pkg::GS_W-1:0] sz);
            group_size = sz;
        endfunction

        function int unsigned group_span();
            int unsigned k;
            k = group_size;
            if (k == 0) k = 1;
            if (k > MAX_GROUP) k = MAX_GROUP;
            return k;
        endfunction

        function void take_value(logic [grs_pkg::DATA_W-1:0] v, logic seq_last);
            int unsigned k;
            int unsigned n;
            bit          full;
            result_t     r;
            k = group_span();
            if (fill_level >= MAX_GROUP) fill_level = 0;
            group_mem[fill_level] = v;
            fill_level++;
            full = (fill_level >= k);
            if (!full && !seq_last) return;
            n = fill_level;
            for (int unsigned i = 0; i < n; i++) begin
                r.value = full ? group_mem[n - 1 - i] : group_mem[i];
                r.run_end = (i + 1 == n);
                r.seq_end = (i + 1 == n) && seq_last;
                expected_out.push_back(r);
            end
            fill_level = 0;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        function void match_output(logic [grs_pkg::DATA_W-1:0] v, logic run_end,
                                   logic seq_end);
            result_t want;
            results_seen++;
            if (expected_out.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer %h last %b user %b",
                                        v, run_end, seq_end));
                return;
            end
            want = expected_out.pop_front();
            if (want.value !== v || want.run_end !== run_end || want.seq_end !== seq_end) begin
                note_mismatch($sformatf("transfer %0d: expected %h/%b/%b got %h/%b/%b",
                                        results_seen, want.value, want.run_end,
                                        want.seq_end, v, run_end, seq_end));
            end
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [grs_pkg::GS_W-1:0]   cfg_wdata = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [grs_pkg::DATA_W-1:0] s_tdata = '0;  // value
    logic                       s_tlast = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [grs_pkg::DATA_W-1:0] m_tdata;       // out_value
    logic                       m_tlast;
    logic                       m_tuser;       // seq_end

    group_reorder reorder;
    bit           sender_gaps = 1'b1;
    bit           receiver_gaps = 1'b1;
    bit           hold_request = 1'b0;
    int unsigned  values_sent = 0;
    int unsigned  size_writes = 0;

    group_reverse_stream #(
        .MAX_GROUP(MAX_GROUP)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // receiver: random stalls, plus one long hold on request
    initial begin : receiver
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (gap - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            reorder.match_output(m_tdata, m_tlast, m_tuser);
        end
    end

    task automatic send_value(input logic [grs_pkg::DATA_W-1:0] v, input logic last);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            s_tdata <= $urandom();
            s_tlast <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        reorder.take_value(v, last);
        values_sent++;
    endtask

    // stop offering, let every expected transfer arrive, then write the size
    task automatic write_group_size(input logic [grs_pkg::GS_W-1:0] sz);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reorder.expected_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= sz;
        @(posedge aclk);
        reorder.set_group_size(sz);
        size_writes++;
        cfg_we <= 1'b0;
    endtask

    task automatic send_sequence(input int len, input bit noisy);
        logic [grs_pkg::DATA_W-1:0] v;
        logic                       last;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = '1;
                default: v = $urandom();
            endcase
            if (noisy) last = ($urandom_range(0, 3) == 0);
            else last = (i == len - 1);
            send_value(v, last);
        end
    endtask

    initial begin : stimulus
        logic [grs_pkg::GS_W-1:0] sz;
        int                       phase;
        int                       phase_items;
        int                       target;
        int                       len;
        int                       drain;
        int unsigned              left_over;

        reorder = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size of two: pair reversed, exact group on last, lone partial
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'h0000_0000, 1'b1);
        send_value(32'h0000_0001, 1'b1);

        // zero acts as one
        write_group_size(5'd0);
        send_value(32'hAAAA_AAAA, 1'b0);

        // above the buffer depth saturates to a full 16 item group
        write_group_size(5'd20);
        for (int i = 0; i < MAX_GROUP; i++) begin
            send_value((i == 0) ? 32'h5555_5555 : $urandom(), 1'b0);
        end

        // size lowered while a group holds three of four items
        write_group_size(5'd4);
        for (int i = 0; i < 3; i++) send_value($urandom(), 1'b0);
        write_group_size(5'd3);
        send_value($urandom(), 1'b0);

        phase = 0;
        while (values_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: sz = 5'd0;
                1: sz = 5'd1;
                2: sz = 5'd16;
                3: sz = 5'($urandom_range(17, 31));
                default: sz = 5'($urandom_range(2, 8));
            endcase
            if (phase == 3) sz = 5'd16;
            write_group_size(sz);
            if (phase == 3) hold_request = 1'b1;
            target = (phase == 3) ? 48 : $urandom_range(10, 40);
            phase_items = 0;
            while (phase_items < target
                   && values_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
                if (values_sent >= DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_TAIL) begin
                    sender_gaps = 1'b0;
                    receiver_gaps = 1'b0;
                end
                len = $urandom_range(1, 2 * reorder.group_span() + 2);
                send_sequence(len, $urandom_range(0, 5) == 0);
                phase_items += len;
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        drain = 0;
        while (reorder.expected_out.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        left_over = reorder.expected_out.size();
        if (left_over != 0) $display("%0d expected transfers never arrived", left_over);

        $display("sent %0d values over %0d phases with %0d group size writes",
                 values_sent, phase, size_writes);
        $display("checked %0d result transfers, %0d mismatches",
                 reorder.results_seen, reorder.mismatches);
        if (reorder.mismatches == 0 && left_over == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/grs_pkg.sv
src/grs_ctrl.sv
src/grs_datapath.sv
src/group_reverse_stream.sv
src/grs_checker.sv
test/tb.sv
